// File: src/iitm_pkg.sv
// Package with the face codes, field widths and shared types of the texel mapper.
package iitm_pkg;

	localparam int KIND_W   = 2;
	localparam int INDEX_W  = 8;
	localparam int POS_W    = 5;
	localparam int TEXEL_W  = 32;
	localparam int DEST_X_W = 10;
	localparam int DEST_Y_W = 8;
	localparam int CHAN_W   = 8;
	localparam int LANES    = 3;

	localparam logic [KIND_W-1:0] KIND_LEFT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RIGHT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TOP   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

	localparam logic [TEXEL_W-1:0] OPAQUE_ALPHA = 32'hFF00_0000;

	// floor(n/3) for n below 512 is floor(n*171/512); with n = 2*avg the
	// constant folds to 342.
	localparam logic [8:0] DARK_MUL   = 9'd342;
	localparam int         DARK_SHIFT = 9;

	localparam logic [DEST_X_W-1:0] HALF_WIDTH      = 10'd16;
	localparam logic [DEST_Y_W-1:0] SIDE_ROW_OFFSET = 8'd8;
	localparam logic [DEST_Y_W-1:0] RIGHT_ROW_BIAS  = 8'd7;

	typedef struct packed {
		logic [DEST_X_W-1:0] dest_x;
		logic [DEST_Y_W-1:0] dest_y;
	} dest_t;

endpackage

// File: src/iitm_lane.sv
// One color channel lane: averages four bytes, then darkens to two thirds.
module iitm_lane (
	input  logic                       clk,
	input  logic [iitm_pkg::CHAN_W-1:0] chan_a,
	input  logic [iitm_pkg::CHAN_W-1:0] chan_b,
	input  logic [iitm_pkg::CHAN_W-1:0] chan_c,
	input  logic [iitm_pkg::CHAN_W-1:0] chan_d,
	output logic [iitm_pkg::CHAN_W-1:0] dark_s2
);
	import iitm_pkg::*;

	logic [CHAN_W+1:0]   sum;
	logic [CHAN_W-1:0]   avg_s1;
	logic [CHAN_W+8:0]   prod;

	assign sum = {2'b00, chan_a} + {2'b00, chan_b} + {2'b00, chan_c} + {2'b00, chan_d};

	always_ff @(posedge clk) begin
		avg_s1 <= sum[CHAN_W+1:2];
	end

	assign prod = {9'd0, avg_s1} * {8'd0, DARK_MUL};

	always_ff @(posedge clk) begin
		dark_s2 <= prod[DARK_SHIFT+CHAN_W-1:DARK_SHIFT];
	end

endmodule

// File: src/iitm_coord.sv
// Destination coordinate mapper for the left, right and top faces.
module iitm_coord (
	input  logic                         clk,
	input  logic [iitm_pkg::KIND_W-1:0]  kind,
	input  logic [iitm_pkg::INDEX_W-1:0] block_index,
	input  logic [iitm_pkg::POS_W-1:0]   col,
	input  logic [iitm_pkg::POS_W-1:0]   row,
	output iitm_pkg::dest_t              dest_s1
);
	import iitm_pkg::*;

	logic [DEST_X_W-1:0] cx;
	logic [DEST_Y_W-1:0] cy;
	logic [DEST_X_W-1:0] x_w;
	logic [DEST_X_W-1:0] xh_w;
	logic [DEST_X_W-1:0] yh_w;
	logic [DEST_Y_W-1:0] x_n;
	logic [DEST_Y_W-1:0] y_n;
	logic [DEST_Y_W-1:0] xh_n;
	logic [DEST_Y_W-1:0] xq_n;
	logic [DEST_Y_W-1:0] yq_n;
	logic [DEST_Y_W-1:0] xo_n;
	dest_t               dest;

	assign cx   = {block_index[4:0], 5'd0};
	assign cy   = {block_index[7:5], 5'd0};
	assign x_w  = {5'd0, col};
	assign xh_w = {6'd0, col[4:1]};
	assign yh_w = {6'd0, row[4:1]};
	assign x_n  = {3'd0, col};
	assign y_n  = {3'd0, row};
	assign xh_n = {4'd0, col[4:1]};
	assign xq_n = {5'd0, col[4:2]};
	assign yq_n = {5'd0, row[4:2]};
	assign xo_n = {7'd0, col[0]};

	always_comb begin
		case (kind)
			KIND_LEFT: begin
				dest.dest_x = cx + x_w;
				dest.dest_y = cy + y_n + SIDE_ROW_OFFSET + xh_n;
			end
			KIND_RIGHT: begin
				dest.dest_x = cx + x_w + HALF_WIDTH;
				dest.dest_y = cy + y_n + SIDE_ROW_OFFSET + RIGHT_ROW_BIAS - xh_n;
			end
			default: begin
				// Top face; the unused code is dropped by the valid pipeline.
				dest.dest_x = cx + HALF_WIDTH + xh_w - yh_w;
				dest.dest_y = cy + xq_n + yq_n + xo_n;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		dest_s1 <= dest;
	end

endmodule

// File: src/isometric_icon_texel_mapper_core.sv
// Top level of the isometric icon texel mapper: color lanes, coordinates and merge.
//
//  channel | handshake     | payload
//  --------+---------------+--------------------------------------------------
//  input   | start / busy  | kind, block_index, col, row, texel_a .. texel_d
//  result  | done (strobe) | dest_x, dest_y, color
//
// The block is a two-stage pipeline and takes one beat in every cycle; busy
// is tied low. Each result comes out of the lane pipeline, where the quad
// average is registered, then the two-thirds multiply is registered, with
// done high for exactly one cycle. An input beat with the unused face code
// produces no result. Reset clears only the valid pipeline; the receiver
// cannot stall, so nothing is held.
module isometric_icon_texel_mapper_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [iitm_pkg::KIND_W-1:0]       kind,
	input  logic [iitm_pkg::INDEX_W-1:0]      block_index,
	input  logic [iitm_pkg::POS_W-1:0]        col,
	input  logic [iitm_pkg::POS_W-1:0]        row,
	input  logic [iitm_pkg::TEXEL_W-1:0]      texel_a,
	input  logic [iitm_pkg::TEXEL_W-1:0]      texel_b,
	input  logic [iitm_pkg::TEXEL_W-1:0]      texel_c,
	input  logic [iitm_pkg::TEXEL_W-1:0]      texel_d,
	output logic                              done,
	output logic [iitm_pkg::DEST_X_W-1:0]     dest_x,
	output logic [iitm_pkg::DEST_Y_W-1:0]     dest_y,
	output logic [iitm_pkg::TEXEL_W-1:0]      color
);
	import iitm_pkg::*;

	logic                     valid_s1;
	logic                     valid_s2;
	logic                     is_top_s1;
	logic                     is_top_s2;
	logic [TEXEL_W-1:0]       top_texel_s1;
	logic [TEXEL_W-1:0]       top_texel_s2;
	dest_t                    dest_s1;
	dest_t                    dest_s2;
	logic [CHAN_W-1:0]        dark_s2 [LANES];

	// The pipeline never stalls, so a new beat is always welcome.
	assign busy = 1'b0;

	// One lane per color channel; alpha is not averaged.
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		iitm_lane u_lane (
			.clk     (clk),
			.chan_a  (texel_a[i*CHAN_W +: CHAN_W]),
			.chan_b  (texel_b[i*CHAN_W +: CHAN_W]),
			.chan_c  (texel_c[i*CHAN_W +: CHAN_W]),
			.chan_d  (texel_d[i*CHAN_W +: CHAN_W]),
			.dark_s2 (dark_s2[i])
		);
	end

	iitm_coord u_coord (
		.clk         (clk),
		.kind        (kind),
		.block_index (block_index),
		.col         (col),
		.row         (row),
		.dest_s1     (dest_s1)
	);

	// Valid pipeline. The unused face code never enters it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy && (kind != KIND_NONE);
			valid_s2 <= valid_s1;
		end
	end

	// Payload that travels alongside the lanes: the top texel is passed
	// through untouched, the coordinates wait one stage for the color.
	always_ff @(posedge clk) begin
		is_top_s1    <= (kind == KIND_TOP);
		top_texel_s1 <= texel_a;
		is_top_s2    <= is_top_s1;
		top_texel_s2 <= top_texel_s1;
		dest_s2      <= dest_s1;
	end

	// Merge stage: side faces get the shaded quad with opaque alpha, the top
	// face gets its texel as it came in.
	assign done   = valid_s2;
	assign dest_x = dest_s2.dest_x;
	assign dest_y = dest_s2.dest_y;
	assign color  = is_top_s2 ? top_texel_s2
	                          : (OPAQUE_ALPHA | {8'd0, dark_s2[2], dark_s2[1], dark_s2[0]});

endmodule
